### sv/c2s_pkg.sv
package c2s_pkg;

  // default configuration
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // result widths
  localparam int AZ_W = 18;
  localparam int EL_W = 17;

  // angle accumulator, units of pi/2^24
  localparam int ANGLE_W = 26;
  localparam int TAB_LEN = 24;

  localparam int HALF_PI = 32768;
  localparam int FULL_PI = 65536;
  localparam int ROUND_BIAS = 128;
  localparam int ROUND_SHIFT = 8;

  // atan(2^-i) in units of pi/2^24
  localparam logic signed [ANGLE_W-1:0] ATAN_TAB [TAB_LEN] = '{
    26'sd4194304, 26'sd2476042, 26'sd1308273, 26'sd664100,
    26'sd333339,  26'sd166832,  26'sd83436,   26'sd41721,
    26'sd20861,   26'sd10430,   26'sd5215,    26'sd2608,
    26'sd1304,    26'sd652,     26'sd326,     26'sd163,
    26'sd81,      26'sd41,      26'sd20,      26'sd10,
    26'sd5,       26'sd3,       26'sd1,       26'sd1
  };

  // special-case flags that ride alongside the datapath
  typedef struct packed {
    logic x_neg;
    logic x_zero;
    logic y_pos;
    logic y_nonneg;
    logic z_pos;
    logic h_zero;
  } flags_t;

endpackage

### sv/c2s_isqrt.sv
module c2s_isqrt #(
  parameter int N = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [2*N-1:0]   rad_i,
  output logic [N-1:0]     root_o
);
  // restoring square root, one root bit per stage
  localparam int RW = N + 3;

  logic [RW-1:0]  rem_q  [N-1];
  logic [2*N-1:0] rad_q  [N-1];
  logic [N-1:0]   root_q [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [RW-1:0]  rem_in;
    logic [2*N-1:0] rad_in;
    logic [N-1:0]   root_in;
    logic [RW-1:0]  cur;
    logic [RW-1:0]  trial;
    logic           ge;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign root_in = root_q[g-1];
    end

    assign cur   = {rem_in[RW-3:0], rad_in[2*N-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[g] <= {root_in[N-2:0], ge};
      end
    end

    if (g < N - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g] <= ge ? (cur - trial) : cur;
          rad_q[g] <= rad_in << 2;
        end
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

### sv/c2s_cordic.sv
module c2s_cordic #(
  parameter int OW     = 34,
  parameter int STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [OW-1:0]          x_i,
  input  logic signed [OW-1:0]          y_i,
  output logic signed [c2s_pkg::EL_W-1:0] angle_o
);
  import c2s_pkg::*;

  // vectoring mode; last stage only needs the angle
  logic signed [OW-1:0]      x_q [STAGES-1];
  logic signed [OW-1:0]      y_q [STAGES-1];
  logic signed [ANGLE_W-1:0] a_q [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic signed [OW-1:0]      x_in;
    logic signed [OW-1:0]      y_in;
    logic signed [ANGLE_W-1:0] a_in;

    if (g == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign a_in = '0;
    end else begin : g_next
      assign x_in = x_q[g-1];
      assign y_in = y_q[g-1];
      assign a_in = a_q[g-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[OW-1]) begin
          a_q[g] <= a_in + ATAN_TAB[g];
        end else begin
          a_q[g] <= a_in - ATAN_TAB[g];
        end
      end
    end

    if (g < STAGES - 1) begin : g_rot
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!y_in[OW-1]) begin
            x_q[g] <= x_in + (y_in >>> g);
            y_q[g] <= y_in - (x_in >>> g);
          end else begin
            x_q[g] <= x_in - (y_in >>> g);
            y_q[g] <= y_in + (x_in >>> g);
          end
        end
      end
    end
  end

  // round half up to pi/65536, then clamp to +-pi/2
  logic signed [ANGLE_W-1:0] rnd;
  assign rnd = (a_q[STAGES-1] + ANGLE_W'(ROUND_BIAS)) >>> ROUND_SHIFT;

  always_comb begin
    if (rnd > ANGLE_W'(HALF_PI)) begin
      angle_o = EL_W'(HALF_PI);
    end else if (rnd < -ANGLE_W'(HALF_PI)) begin
      angle_o = -EL_W'(HALF_PI);
    end else begin
      angle_o = EL_W'(rnd);
    end
  end

endmodule

### sv/cartesian_to_spherical.sv
// Channel  Dir  Handshake               Beat payload
// in       in   in_valid_i/in_stall_o   coord_x_i, coord_y_i, coord_z_i
// out      out  out_valid_o/out_stall_i azimuth_o, elevation_o, range_len_o
//
// One point per cycle while the output is not stalled. The depth is set by
// the NH-bit horizontal-length square root (NH = COORD_WIDTH + FRAC, 31 at
// defaults) followed by the elevation CORDIC.
// Reset clears only the valid bits. A stall on the output freezes the whole
// pipeline in place; nothing is dropped or repeated.
module cartesian_to_spherical #(
  parameter int COORD_WIDTH   = c2s_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]   coord_x_i,
  input  logic signed [COORD_WIDTH-1:0]   coord_y_i,
  input  logic signed [COORD_WIDTH-1:0]   coord_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [c2s_pkg::AZ_W-1:0] azimuth_o,
  output logic signed [c2s_pkg::EL_W-1:0] elevation_o,
  output logic        [COORD_WIDTH-1:0]   range_len_o
);
  import c2s_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int S    = CORDIC_STAGES;
  localparam int FRAC = (63 - 2 * W) / 2;   // fractional bits of CORDIC operands
  localparam int NH   = W + FRAC;           // bits of horizontal length
  localparam int OW   = W + FRAC + 3;       // CORDIC operand width, covers gain
  localparam int TOT  = NH + S;             // delay-line depth from stage 2 to final stage
  localparam int DR   = TOT - W;            // range delay after its square root

  // global advance: the whole pipe moves unless a held result is stalled
  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // ---- stage 1: capture and square -----------------------------------------
  logic                  s1_valid_q;
  logic signed [W-1:0]   x1_q, y1_q, z1_q;
  logic [2*W-1:0]        sqx1_q, sqy1_q, sqz1_q;
  logic signed [2*W-1:0] px, py, pz;

  assign px = coord_x_i * coord_x_i;
  assign py = coord_y_i * coord_y_i;
  assign pz = coord_z_i * coord_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q   <= coord_x_i;
      y1_q   <= coord_y_i;
      z1_q   <= coord_z_i;
      sqx1_q <= px;
      sqy1_q <= py;
      sqz1_q <= pz;
    end
  end

  // ---- stage 2: sums, CORDIC operand prep, special-case flags --------------
  logic                 s2_valid_q;
  logic [2*W-1:0]       hsq2_q, rsq2_q;
  logic signed [OW-1:0] ax2_q, ay2_q, ez2_q;
  flags_t               fl2_q;
  logic [2*W-1:0]       hsq_d;
  logic signed [OW-1:0] xs, ys;

  assign hsq_d = sqx1_q + sqy1_q;
  assign xs    = OW'(x1_q) <<< FRAC;
  assign ys    = OW'(y1_q) <<< FRAC;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hsq2_q <= hsq_d;
      rsq2_q <= hsq_d + sqz1_q;
      // left half-plane runs on the mirrored point
      ax2_q  <= x1_q[W-1] ? -xs : xs;
      ay2_q  <= x1_q[W-1] ? -ys : ys;
      ez2_q  <= OW'(z1_q) <<< FRAC;
      fl2_q.x_neg    <= x1_q[W-1];
      fl2_q.x_zero   <= (x1_q == '0);
      fl2_q.y_pos    <= !y1_q[W-1] && (y1_q != '0);
      fl2_q.y_nonneg <= !y1_q[W-1];
      fl2_q.z_pos    <= !z1_q[W-1] && (z1_q != '0);
      fl2_q.h_zero   <= (x1_q == '0) && (y1_q == '0);
    end
  end

  // ---- square roots --------------------------------------------------------
  logic [2*NH-1:0] h_rad;
  logic [NH-1:0]   h_root;
  logic [W-1:0]    r_root;

  assign h_rad = (2 * NH)'(hsq2_q) << (2 * FRAC);

  c2s_isqrt #(.N(NH)) u_hsqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (h_rad),
    .root_o (h_root)
  );

  c2s_isqrt #(.N(W)) u_rsqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rsq2_q),
    .root_o (r_root)
  );

  // ---- alignment delay lines -----------------------------------------------
  logic signed [OW-1:0] dax_q [NH];
  logic signed [OW-1:0] day_q [NH];
  logic signed [OW-1:0] dez_q [NH];
  flags_t               dfl_q [TOT];
  logic [W-1:0]         drg_q [DR];
  logic                 dv_q  [TOT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dax_q[0] <= ax2_q;
      day_q[0] <= ay2_q;
      dez_q[0] <= ez2_q;
      for (int i = 1; i < NH; i++) begin
        dax_q[i] <= dax_q[i-1];
        day_q[i] <= day_q[i-1];
        dez_q[i] <= dez_q[i-1];
      end
      dfl_q[0] <= fl2_q;
      for (int i = 1; i < TOT; i++) begin
        dfl_q[i] <= dfl_q[i-1];
      end
      drg_q[0] <= r_root;
      for (int i = 1; i < DR; i++) begin
        drg_q[i] <= drg_q[i-1];
      end
    end
  end

  // ---- CORDICs -------------------------------------------------------------
  logic signed [EL_W-1:0] az_core, el_core;

  c2s_cordic #(.OW(OW), .STAGES(S)) u_az_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (dax_q[NH-1]),
    .y_i     (day_q[NH-1]),
    .angle_o (az_core)
  );

  c2s_cordic #(.OW(OW), .STAGES(S)) u_el_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (OW'(h_root)),
    .y_i     (dez_q[NH-1]),
    .angle_o (el_core)
  );

  // ---- final stage: quadrant fix-up and special cases ----------------------
  flags_t                 flf;
  logic signed [AZ_W:0]   az_wide;
  logic signed [AZ_W-1:0] az_d;
  logic signed [EL_W-1:0] el_d;

  assign flf = dfl_q[TOT-1];

  always_comb begin
    az_wide = (AZ_W + 1)'(az_core) +
              (flf.y_nonneg ? (AZ_W + 1)'(FULL_PI) : -(AZ_W + 1)'(FULL_PI));
    if (flf.x_zero) begin
      az_d = flf.y_pos ? AZ_W'(HALF_PI) : -AZ_W'(HALF_PI);
    end else if (flf.x_neg) begin
      if (az_wide > (AZ_W + 1)'(FULL_PI)) begin
        az_d = AZ_W'(FULL_PI);
      end else if (az_wide < -(AZ_W + 1)'(FULL_PI)) begin
        az_d = -AZ_W'(FULL_PI);
      end else begin
        az_d = AZ_W'(az_wide);
      end
    end else begin
      az_d = AZ_W'(az_core);
    end

    if (flf.h_zero) begin
      el_d = flf.z_pos ? EL_W'(HALF_PI) : -EL_W'(HALF_PI);
    end else begin
      el_d = el_core;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      azimuth_o   <= az_d;
      elevation_o <= el_d;
      range_len_o <= drg_q[DR-1];
    end
  end

  // ---- valid bits ----------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < TOT; i++) begin
        dv_q[i] <= 1'b0;
      end
    end else if (en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      dv_q[0]     <= s2_valid_q;
      for (int i = 1; i < TOT; i++) begin
        dv_q[i] <= dv_q[i-1];
      end
      out_valid_o <= dv_q[TOT-1];
    end
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import c2s_pkg::*;

  localparam int CW         = COORD_WIDTH_DEF;
  localparam int STAGES     = CORDIC_STAGES_DEF;
  localparam int FRAC_BITS  = (63 - 2 * CW) / 2;
  // pipeline depth of the DUT; the drain wait adds slack on top
  localparam int PIPE_DEPTH = CW + FRAC_BITS + STAGES + 3;
  localparam int DRAIN_CYC  = PIPE_DEPTH + 20;
  localparam int RAND_PTS   = 1400;
  localparam int HOLD_CYC   = 300;

  // one spherical result
  typedef struct {
    logic signed [AZ_W-1:0] az;
    logic signed [EL_W-1:0] el;
    logic        [CW-1:0]   rng;
  } sph_t;

  // directed row; known = 1 means the result is typed in below
  typedef struct {
    int x;
    int y;
    int z;
    bit known;
    int az;
    int el;
    int rng;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [CW-1:0]   coord_x_i = '0;
  logic signed [CW-1:0]   coord_y_i = '0;
  logic signed [CW-1:0]   coord_z_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [AZ_W-1:0] azimuth_o;
  logic signed [EL_W-1:0] elevation_o;
  logic        [CW-1:0]   range_len_o;

  sph_t sph_expect_q[$];
  int   mismatch_cnt = 0;
  int   snd_idle = 38;
  int   rcv_idle = 55;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;

  always #10 clk_i = ~clk_i;

  cartesian_to_spherical u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .coord_z_i   (coord_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .azimuth_o   (azimuth_o),
    .elevation_o (elevation_o),
    .range_len_o (range_len_o)
  );

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // bitwise integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // vectoring CORDIC for xv > 0; angle in pi/65536, accumulated in pi/2^24
  function automatic longint vec_angle(longint xv, longint yv);
    longint acc;
    longint dx;
    longint dy;
    acc = 0;
    for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
      dx = yv >>> i;   // floor shift
      dy = xv >>> i;
      if (yv >= 0) begin
        xv  = xv + dx;
        yv  = yv - dy;
        acc = acc + longint'(ATAN_TAB[i]);
      end else begin
        xv  = xv - dx;
        yv  = yv + dy;
        acc = acc - longint'(ATAN_TAB[i]);
      end
    end
    return sat((acc + ROUND_BIAS) >>> ROUND_SHIFT, HALF_PI);
  endfunction

  function automatic sph_t to_spherical(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                        logic signed [CW-1:0] pz);
    sph_t            r;
    longint          x;
    longint          y;
    longint          z;
    longint          scale;
    longint          azv;
    longint          elv;
    longint unsigned hsq;
    x     = px;
    y     = py;
    z     = pz;
    scale = longint'(1) << FRAC_BITS;
    hsq   = longint'(x * x + y * y);
    if (x > 0) begin
      azv = vec_angle(x * scale, y * scale);
    end else if (x < 0) begin
      // left half plane: rotate by pi, then unwrap
      azv = vec_angle(-x * scale, -y * scale);
      azv = azv + ((y >= 0) ? FULL_PI : -FULL_PI);
      azv = sat(azv, FULL_PI);
    end else begin
      azv = (y > 0) ? HALF_PI : -HALF_PI;
    end
    if (hsq == 0) begin
      elv = (z > 0) ? HALF_PI : -HALF_PI;
    end else begin
      elv = vec_angle(longint'(int_sqrt(hsq << (2 * FRAC_BITS))), z * scale);
    end
    r.az  = azv[AZ_W-1:0];
    r.el  = elv[EL_W-1:0];
    r.rng = CW'(int_sqrt(hsq + longint'(z * z)));
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input side: offer one point, hold it until taken, log its expectation
  // ---------------------------------------------------------------------
  task automatic send_point(int x, int y, int z, bit known, sph_t typed);
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
    px = x[CW-1:0];
    py = y[CW-1:0];
    pz = z[CW-1:0];
    // random gaps before the beat; called at a falling edge
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i  <= px;
    coord_y_i  <= py;
    coord_z_i  <= pz;
    do @(posedge clk_i); while (in_stall_o);
    sph_expect_q.push_back(known ? typed : to_spherical(px, py, pz));
    @(negedge clk_i);
  endtask

  // mix of extremes, small values, zeros and full range
  function automatic int pick_coord();
    case ($urandom_range(7))
      0: return 0;
      1: return ($urandom_range(1)) ? 32767 : -32768;
      2: return int'($urandom_range(8)) - 4;
      3: return int'($urandom_range(512)) - 256;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Output side: stall pattern, with one long hold-off on request
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYC;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle);
    end
  end

  // scoreboard: every accepted beat against the oldest expectation
  always @(posedge clk_i) begin
    sph_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sph_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected beat: az=%0d el=%0d rng=%0d",
                   azimuth_o, elevation_o, range_len_o);
      end else begin
        e = sph_expect_q.pop_front();
        if (azimuth_o !== e.az || elevation_o !== e.el || range_len_o !== e.rng) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp az=%0d el=%0d rng=%0d, got az=%0d el=%0d rng=%0d",
                     e.az, e.el, e.rng, azimuth_o, elevation_o, range_len_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  // Directed points: on-axis cases (x zero, origin, x and y zero), the
  // left half plane with y zero and y negative, and the field extremes.
  // Only points with no horizontal length have a result typed in.
  dir_row_t dir_tab[18] = '{
    '{0, 0, 0, 1, -32768, -32768, 0},
    '{0, 0, 7, 1, -32768, 32768, 7},
    '{0, 0, -32768, 1, -32768, -32768, 32768},
    '{0, 0, 32767, 1, -32768, 32768, 32767},
    '{0, 1, 0, 0, 0, 0, 0},
    '{0, -1, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0, 0, 0},
    '{-1, 0, 0, 0, 0, 0, 0},
    '{-1, -1, 0, 0, 0, 0, 0},
    '{-32768, 0, 0, 0, 0, 0, 0},
    '{-32768, -1, 5, 0, 0, 0, 0},
    '{32767, 32767, 32767, 0, 0, 0, 0},
    '{-32768, -32768, -32768, 0, 0, 0, 0},
    '{32767, -32768, 0, 0, 0, 0, 0},
    '{0, 32767, -32768, 0, 0, 0, 0},
    '{-3, 4, 12, 0, 0, 0, 0},
    '{5, 5, -9, 0, 0, 0, 0},
    '{-21845, 10922, -5461, 0, 0, 0, 0}
  };

  initial begin
    sph_t typed;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      typed.az  = AZ_W'(dir_tab[i].az);
      typed.el  = EL_W'(dir_tab[i].el);
      typed.rng = CW'(dir_tab[i].rng);
      send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].known, typed);
    end

    for (int n = 0; n < RAND_PTS; n++) begin
      // idling phases: receiver-heavy, then sender-heavy, then none
      if (n == RAND_PTS / 3) begin
        snd_idle = 55;
        rcv_idle = 38;
      end
      if (n == 2 * RAND_PTS / 3) begin
        snd_idle = 0;
        rcv_idle = 0;
        hold_req = 1'b1;   // long hold-off while beats keep coming
      end
      if (n == 2 * RAND_PTS / 3 + 150) hold_req = 1'b0;
      if (n == RAND_PTS / 2) begin
        // sender pause: let the pipeline drain completely
        in_valid_i <= 1'b0;
        wait (sph_expect_q.size() == 0);
        @(negedge clk_i);
      end
      send_point(pick_coord(), pick_coord(), pick_coord(), 1'b0, typed);
    end
    in_valid_i <= 1'b0;
    hold_req = 1'b0;

    wait (sph_expect_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatch_cnt == 0 && sph_expect_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

### sim.f
sv/c2s_pkg.sv
sv/c2s_isqrt.sv
sv/c2s_cordic.sv
sv/cartesian_to_spherical.sv
verif/tb_top.sv
